// ===== sv/rrpp_pkg.sv =====
// shared types and constants for the round-robin process picker
`timescale 1ns / 1ps

package rrpp_pkg;

  // default slot count
  localparam int NUM_SLOTS_DEF = 16;

  // field widths
  localparam int PID_W   = 4;
  localparam int STATE_W = 2;

  // slot state codes
  localparam logic [STATE_W-1:0] ST_COLD    = 2'd0;
  localparam logic [STATE_W-1:0] ST_READY   = 2'd1;
  localparam logic [STATE_W-1:0] ST_RUNNING = 2'd2;
  localparam logic [STATE_W-1:0] ST_EXITED  = 2'd3;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCHED = 1'b1;

  // policy codes
  localparam logic POL_ROUND_ROBIN = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic sweep;
    logic commit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

// ===== sv/rrpp_ctrl.sv =====
// controller state machine for the round-robin process picker
`timescale 1ns / 1ps

module rrpp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  input  logic             out_ready,
  input  rrpp_pkg::status_t status,
  output logic             in_ready,
  output rrpp_pkg::cmd_t   cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SWEEP  = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // the result register can take a new result
  assign out_free = !status.out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = (in_op == rrpp_pkg::OP_SCHED) ? S_SWEEP : S_COMMIT;
        end
      end
      S_SWEEP: begin
        cmd.sweep  = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/rrpp_dp.sv =====
// slot table, search and result register for the round-robin process picker
`timescale 1ns / 1ps

module rrpp_dp #(
  parameter int NUM_SLOTS = rrpp_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rrpp_pkg::cmd_t               cmd,
  input  logic                         policy,
  input  logic                         operation,
  input  logic [rrpp_pkg::PID_W-1:0]   slot_id,
  input  logic [rrpp_pkg::STATE_W-1:0] new_state,
  input  logic                         out_ready,
  output rrpp_pkg::status_t            status,
  output logic                         out_valid,
  output logic [rrpp_pkg::PID_W-1:0]   next_pid,
  output logic                         found,
  output logic                         previous_alive
);

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int START_N = (1 << rrpp_pkg::PID_W) + 1;

  logic [rrpp_pkg::STATE_W-1:0] slot_state [NUM_SLOTS];

  // latched item
  logic                         item_op;
  logic [rrpp_pkg::PID_W-1:0]   item_sid;
  logic [rrpp_pkg::STATE_W-1:0] item_ns;

  // sweep results
  logic [NUM_SLOTS-1:0] search_vec;
  logic [SLOT_W-1:0]    search_start;
  logic                 alive_q;

  logic [NUM_SLOTS-1:0]   ready_clean;
  logic [NUM_SLOTS-1:0]   ready_rev;
  logic [2*NUM_SLOTS-1:0] ready_dbl;
  logic [2*NUM_SLOTS-1:0] ready_shift;
  logic [rrpp_pkg::PID_W:0] cur_plus1;
  logic [SLOT_W-1:0]      start;
  logic [SLOT_W-1:0]      sid_idx;
  logic                   sid_in_range;
  logic                   alive_next;

  logic [SLOT_W-1:0] off;
  logic              any_ready;
  logic [SLOT_W:0]   rr_sum;
  logic [SLOT_W-1:0] pick;

  assign sid_idx      = SLOT_W'(item_sid);
  assign sid_in_range = 32'(item_sid) < NUM_SLOTS;

  // ready set as it stands after exit cleanup
  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      ready_clean[k] = (slot_state[k] == rrpp_pkg::ST_READY) ||
                       (slot_state[k] == rrpp_pkg::ST_RUNNING);
      ready_rev[k]   = (slot_state[NUM_SLOTS-1-k] == rrpp_pkg::ST_READY) ||
                       (slot_state[NUM_SLOTS-1-k] == rrpp_pkg::ST_RUNNING);
    end
  end

  // round-robin start slot, (current + 1) mod slot count, as a small table
  assign cur_plus1 = {1'b0, item_sid} + 1'b1;
  always_comb begin
    start = '0;
    for (int v = 0; v < START_N; v++) begin
      if (32'(cur_plus1) == v) begin
        start = SLOT_W'(v % NUM_SLOTS);
      end
    end
  end

  // rotate so that the start slot lands on bit zero
  assign ready_dbl   = {ready_clean, ready_clean};
  assign ready_shift = ready_dbl >> start;
  assign alive_next  = sid_in_range &&
                       ((slot_state[sid_idx] == rrpp_pkg::ST_READY) ||
                        (slot_state[sid_idx] == rrpp_pkg::ST_RUNNING));

  // lowest set bit of the search vector
  always_comb begin
    off = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (search_vec[k]) begin
        off = SLOT_W'(k);
      end
    end
  end
  assign any_ready = |search_vec;

  // map the offset back to a slot number
  assign rr_sum = {1'b0, search_start} + {1'b0, off};
  always_comb begin
    if (policy != rrpp_pkg::POL_ROUND_ROBIN) begin
      pick = SLOT_W'(NUM_SLOTS - 1) - off;
    end else if (32'(rr_sum) >= NUM_SLOTS) begin
      pick = SLOT_W'(32'(rr_sum) - NUM_SLOTS);
    end else begin
      pick = rr_sum[SLOT_W-1:0];
    end
  end

  // item latch and sweep registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_op  <= operation;
      item_sid <= slot_id;
      item_ns  <= new_state;
    end
    if (cmd.sweep) begin
      search_vec   <= (policy != rrpp_pkg::POL_ROUND_ROBIN) ?
                      ready_rev : ready_shift[NUM_SLOTS-1:0];
      search_start <= start;
      alive_q      <= alive_next;
    end
  end

  // slot table: cleanup on sweep, write or pick on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_state[k] <= rrpp_pkg::ST_COLD;
      end
    end else if (cmd.sweep) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (slot_state[k] == rrpp_pkg::ST_EXITED) begin
          slot_state[k] <= rrpp_pkg::ST_COLD;
        end else if (slot_state[k] == rrpp_pkg::ST_RUNNING) begin
          slot_state[k] <= rrpp_pkg::ST_READY;
        end
      end
    end else if (cmd.commit) begin
      if (item_op == rrpp_pkg::OP_WRITE) begin
        if (sid_in_range) begin
          slot_state[sid_idx] <= item_ns;
        end
      end else if (any_ready) begin
        slot_state[pick] <= rrpp_pkg::ST_RUNNING;
      end
    end
  end

  // result register, valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register, payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (item_op == rrpp_pkg::OP_SCHED) begin
        next_pid       <= any_ready ? rrpp_pkg::PID_W'(pick) : '0;
        found          <= any_ready;
        previous_alive <= alive_q;
      end else begin
        next_pid       <= '0;
        found          <= 1'b0;
        previous_alive <= 1'b0;
      end
    end
  end

  assign status.out_valid = out_valid;

endmodule

// ===== sv/round_robin_process_picker.sv =====
// top level of the round-robin process picker
//
//   channel  | signals                                           | direction
//   ---------+---------------------------------------------------+----------
//   config   | psel penable pwrite paddr pwdata prdata pready    | in / out
//   item     | in_valid in_ready operation slot_id new_state     | in
//   result   | out_valid out_ready next_pid found previous_alive | out
//
// a write item steps through transfer and commit, a schedule item through transfer,
// sweep of the slot table and commit; the result register is loaded at commit
// one item is in flight at a time; a new item transfers while a result waits
// commit holds while the result register is full and not being taken
// reset (synchronous) clears every slot to cold and the policy to round robin
`timescale 1ns / 1ps

module round_robin_process_picker #(
  parameter int NUM_SLOTS = rrpp_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [rrpp_pkg::PID_W-1:0]   slot_id,
  input  logic [rrpp_pkg::STATE_W-1:0] new_state,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rrpp_pkg::PID_W-1:0]   next_pid,
  output logic                         found,
  output logic                         previous_alive
);

  localparam logic ADDR_POLICY = 1'b0;

  logic              policy;
  rrpp_pkg::cmd_t    cmd;
  rrpp_pkg::status_t status;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_POLICY) ? {31'b0, policy} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= rrpp_pkg::POL_ROUND_ROBIN;
    end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_POLICY)) begin
      policy <= pwdata[0];
    end
  end

  // controller
  rrpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (operation),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // datapath
  rrpp_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .policy         (policy),
    .operation      (operation),
    .slot_id        (slot_id),
    .new_state      (new_state),
    .out_ready      (out_ready),
    .status         (status),
    .out_valid      (out_valid),
    .next_pid       (next_pid),
    .found          (found),
    .previous_alive (previous_alive)
  );

`ifndef SYNTH
  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item transfer while another item is in flight");

  // a sweep is always followed by its commit step
  a_sweep_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |=> !cmd.sweep && !cmd.latch)
    else $error("sweep not followed by commit");

  // commit never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !out_valid || out_ready)
    else $error("result overwritten");

  // no slot chosen means a zero pid
  a_zero_pid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> next_pid == '0)
    else $error("non-zero pid without a chosen slot");
`endif

endmodule

// ===== tb/sv/tb_round_robin_process_picker.sv =====
// self-checking testbench for the round-robin process picker
`timescale 1ns / 1ps

module tb_round_robin_process_picker;

  localparam int NUM_SLOTS   = rrpp_pkg::NUM_SLOTS_DEF;
  localparam int PID_W       = rrpp_pkg::PID_W;
  localparam int STATE_W     = rrpp_pkg::STATE_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam logic [2:0] REG_POLICY = 3'd0;
  localparam logic POL_HIGHEST = 1'b1;

  // one result of the picker
  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic             found;
    logic             alive;
  } pick_t;

  // slot table mirror and the queue of picks still owed by the block
  class pick_scoreboard;
    logic [STATE_W-1:0] slots [NUM_SLOTS];
    logic               policy;
    logic [PID_W-1:0]   running_pid;
    pick_t              owed [$];
    int                 errors;
    int                 n_items;
    int                 n_sched;
    int                 n_found;

    function new();
      foreach (slots[k]) slots[k] = rrpp_pkg::ST_COLD;
      policy      = rrpp_pkg::POL_ROUND_ROBIN;
      running_pid = '0;
      errors      = 0;
      n_items     = 0;
      n_sched     = 0;
      n_found     = 0;
    endfunction

    function void set_policy(logic p);
      policy = p;
    endfunction

    // next state of the slot table and the pick it yields
    function pick_t pick_next(logic op, logic [PID_W-1:0] sid, logic [STATE_W-1:0] ns);
      pick_t res;
      int    idx;
      res = '0;
      idx = -1;
      if (op == rrpp_pkg::OP_WRITE) begin
        if (sid < NUM_SLOTS) slots[sid] = ns;
        return res;
      end
      n_sched++;
      // exited slots go cold, running slots go back to ready
      foreach (slots[k]) begin
        if (slots[k] == rrpp_pkg::ST_EXITED) slots[k] = rrpp_pkg::ST_COLD;
        else if (slots[k] == rrpp_pkg::ST_RUNNING) slots[k] = rrpp_pkg::ST_READY;
      end
      res.alive = (sid < NUM_SLOTS) && (slots[sid] != rrpp_pkg::ST_COLD);
      // round robin visits the current slot last
      if (policy == rrpp_pkg::POL_ROUND_ROBIN) begin
        for (int i = 1; i <= NUM_SLOTS; i++) begin
          if (slots[(int'(sid) + i) % NUM_SLOTS] == rrpp_pkg::ST_READY) begin
            idx = (int'(sid) + i) % NUM_SLOTS;
            break;
          end
        end
      end else begin
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
          if (slots[k] == rrpp_pkg::ST_READY) begin
            idx = k;
            break;
          end
        end
      end
      if (idx >= 0) begin
        slots[idx]  = rrpp_pkg::ST_RUNNING;
        res.pid     = idx[PID_W-1:0];
        res.found   = 1'b1;
        running_pid = res.pid;
        n_found++;
      end
      return res;
    endfunction

    function void note_item(logic op, logic [PID_W-1:0] sid, logic [STATE_W-1:0] ns);
      n_items++;
      owed.push_back(pick_next(op, sid, ns));
    endfunction

    task report_mismatch(string msg);
      if (errors < 50) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [PID_W-1:0] pid, logic fnd, logic alive);
      pick_t want;
      if (owed.size() == 0) begin
        report_mismatch("result transfer with nothing owed");
        return;
      end
      want = owed.pop_front();
      if (pid !== want.pid)
        report_mismatch($sformatf("next_pid %0d, expected %0d", pid, want.pid));
      if (fnd !== want.found)
        report_mismatch($sformatf("found %b, expected %b", fnd, want.found));
      if (alive !== want.alive)
        report_mismatch($sformatf("previous_alive %b, expected %b", alive, want.alive));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = rrpp_pkg::OP_WRITE;
  logic [PID_W-1:0]   slot_id = '0;
  logic [STATE_W-1:0] new_state = rrpp_pkg::ST_COLD;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PID_W-1:0]   next_pid;
  logic               found;
  logic               previous_alive;

  pick_scoreboard sb = new();
  bit             send_idle = 1'b1;
  bit             take_idle = 1'b1;
  int             cycles = 0;
  int             n_policy_writes = 0;

  round_robin_process_picker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .slot_id(slot_id),
    .new_state(new_state),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .next_pid(next_pid),
    .found(found),
    .previous_alive(previous_alive)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, check every transfer
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = take_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(next_pid, found, previous_alive);
    end
  end

  // one item on the input channel; valid is left high after the transfer
  task automatic send_item(logic op, logic [PID_W-1:0] sid, logic [STATE_W-1:0] ns);
    int gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    slot_id   <= sid;
    new_state <= ns;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, sid, ns);
  endtask

  // drop valid and wait for every owed result, then let the block settle
  task automatic hold_off();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write: setup then access cycle
  task automatic write_policy(logic p);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_POLICY;
    pwdata  <= {31'd0, p};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_policy(p);
    n_policy_writes++;
  endtask

  // random item: mostly slot updates biased to ready, schedules mostly from the running pid
  task automatic random_item();
    int               r;
    int               s;
    logic [PID_W-1:0] sid;
    logic [STATE_W-1:0] ns;
    r   = $urandom_range(0, 99);
    sid = PID_W'($urandom_range(0, NUM_SLOTS - 1));
    ns  = STATE_W'($urandom_range(0, 3));
    if (r < 30) begin
      if ($urandom_range(0, 3) != 0) sid = sb.running_pid;
      send_item(rrpp_pkg::OP_SCHED, sid, ns);
    end else begin
      s = $urandom_range(0, 99);
      if (s < 40) ns = rrpp_pkg::ST_READY;
      else if (s < 60) ns = rrpp_pkg::ST_COLD;
      else if (s < 75) ns = rrpp_pkg::ST_RUNNING;
      else ns = rrpp_pkg::ST_EXITED;
      send_item(rrpp_pkg::OP_WRITE, sid, ns);
    end
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: round robin, empty table, wrap, exit cleanup, current last
    write_policy(rrpp_pkg::POL_ROUND_ROBIN);
    send_item(rrpp_pkg::OP_SCHED, 4'd0, rrpp_pkg::ST_COLD);
    send_item(rrpp_pkg::OP_WRITE, 4'd0, rrpp_pkg::ST_READY);
    send_item(rrpp_pkg::OP_WRITE, 4'd15, rrpp_pkg::ST_READY);
    send_item(rrpp_pkg::OP_WRITE, 4'd7, rrpp_pkg::ST_EXITED);
    send_item(rrpp_pkg::OP_WRITE, 4'd3, rrpp_pkg::ST_RUNNING);
    send_item(rrpp_pkg::OP_WRITE, 4'd9, rrpp_pkg::ST_COLD);
    send_item(rrpp_pkg::OP_SCHED, 4'd15, rrpp_pkg::ST_EXITED);
    send_item(rrpp_pkg::OP_SCHED, 4'd0, rrpp_pkg::ST_READY);
    send_item(rrpp_pkg::OP_SCHED, 4'd3, rrpp_pkg::ST_RUNNING);
    send_item(rrpp_pkg::OP_WRITE, 4'd15, rrpp_pkg::ST_EXITED);
    send_item(rrpp_pkg::OP_SCHED, 4'd15, rrpp_pkg::ST_COLD);
    send_item(rrpp_pkg::OP_WRITE, 4'd3, rrpp_pkg::ST_COLD);
    send_item(rrpp_pkg::OP_SCHED, 4'd0, rrpp_pkg::ST_COLD);
    hold_off();

    // directed: highest ready slot
    write_policy(POL_HIGHEST);
    send_item(rrpp_pkg::OP_WRITE, 4'd5, rrpp_pkg::ST_READY);
    send_item(rrpp_pkg::OP_SCHED, 4'd0, rrpp_pkg::ST_READY);
    send_item(rrpp_pkg::OP_SCHED, 4'd5, rrpp_pkg::ST_COLD);
    send_item(rrpp_pkg::OP_WRITE, 4'd5, rrpp_pkg::ST_EXITED);
    send_item(rrpp_pkg::OP_SCHED, 4'd5, rrpp_pkg::ST_EXITED);
    send_item(rrpp_pkg::OP_WRITE, 4'd0, rrpp_pkg::ST_COLD);
    send_item(rrpp_pkg::OP_SCHED, 4'd0, rrpp_pkg::ST_RUNNING);
    hold_off();

    // random phases, each with its own policy and idling mix
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_policy(p[0] ? rrpp_pkg::POL_ROUND_ROBIN : POL_HIGHEST);
      send_idle = $urandom_range(0, 3) != 0;
      take_idle = $urandom_range(0, 3) != 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
        if ($urandom_range(0, 99) == 0) hold_off();
      end
      hold_off();
    end

    send_idle = 1'b1;
    take_idle = 1'b1;
    repeat (8) @(posedge clk);
    $display("ran %0d items, %0d schedules, %0d with a slot picked, %0d with none ready",
             sb.n_items, sb.n_sched, sb.n_found, sb.n_sched - sb.n_found);
    $display("policy register written %0d times, %0d mismatches",
             n_policy_writes, sb.errors);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rrpp_pkg.sv
sv/rrpp_ctrl.sv
sv/rrpp_dp.sv
sv/round_robin_process_picker.sv
tb/sv/tb_round_robin_process_picker.sv
